// File: rtl/triangle_tangent_generator_defines.svh
// ============================================================================
// Triangle tangent generator assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ============================================================================
`ifndef TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH
`define TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define TTG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ttg_pkg.sv
// ============================================================================
// ttg_pkg
// Constants and types of the triangle tangent generator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
package ttg_pkg;
    localparam int COORD_BITS   = 32;
    localparam int VERTEX_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 12;
    localparam int RED_BITS     = 20;
    localparam int EDGE_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int DIFF_W       = PROD_W + 1;
    localparam int LEN_W        = $clog2(DIFF_W + 1);
    localparam int SQ_W         = 2 * RED_BITS;
    localparam int SUM_W        = SQ_W + 2;
    localparam int D2_W         = SQ_W + 16;
    localparam int PRD_W        = SUM_W + 16;
    localparam int STEPS        = 8;

    localparam logic       ACT_LOAD = 1'b0;
    localparam logic       ACT_TRI  = 1'b1;
    localparam logic [7:0] BYTE_MID = 8'd127;
    localparam logic [7:0] HW_NEG   = 8'd0;
    localparam logic [7:0] HW_POS   = 8'd254;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [ADDR_W-1:0]            t_addr;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        t_coord u;
        t_coord v;
    } t_vertex;

    typedef struct packed {
        t_idx c0;
        t_idx c1;
        t_idx c2;
    } t_corners;

    typedef struct packed {
        logic [7:0] tx;
        logic [7:0] ty;
        logic [7:0] tz;
        logic [7:0] hw;
        logic       degen;
        t_corners   c;
    } t_result;

    // control between sequencer and datapath
    typedef struct packed {
        logic en;
        logic launch;
    } t_pipe_ctl;
endpackage
`default_nettype wire

// File: rtl/ttg_ifs.sv
// ============================================================================
// ttg interfaces
// Valid/ready channels for vertex/triangle items and tangent results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
interface ttg_item_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [ttg_pkg::IDX_W-1:0]        first_corner;
    logic [ttg_pkg::IDX_W-1:0]        second_corner;
    logic [ttg_pkg::IDX_W-1:0]        third_corner;
    logic signed [ttg_pkg::COORD_BITS-1:0] position_x;
    logic signed [ttg_pkg::COORD_BITS-1:0] position_y;
    logic signed [ttg_pkg::COORD_BITS-1:0] position_z;
    logic signed [ttg_pkg::COORD_BITS-1:0] texture_u;
    logic signed [ttg_pkg::COORD_BITS-1:0] texture_v;
    modport source (output valid, action, first_corner, second_corner, third_corner,
                    position_x, position_y, position_z, texture_u, texture_v,
                    input ready);
    modport sink   (input valid, action, first_corner, second_corner, third_corner,
                    position_x, position_y, position_z, texture_u, texture_v,
                    output ready);
endinterface

interface ttg_result_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                tangent_x_byte;
    logic [7:0]                tangent_y_byte;
    logic [7:0]                tangent_z_byte;
    logic [7:0]                handedness_byte;
    logic                      degenerate;
    logic [ttg_pkg::IDX_W-1:0] out_first_corner;
    logic [ttg_pkg::IDX_W-1:0] out_second_corner;
    logic [ttg_pkg::IDX_W-1:0] out_third_corner;
    modport source (output valid, tangent_x_byte, tangent_y_byte, tangent_z_byte,
                    handedness_byte, degenerate, out_first_corner, out_second_corner,
                    out_third_corner, input ready);
    modport sink   (input valid, tangent_x_byte, tangent_y_byte, tangent_z_byte,
                    handedness_byte, degenerate, out_first_corner, out_second_corner,
                    out_third_corner, output ready);
endinterface
`default_nettype wire

// File: rtl/ttg_vertex_ram.sv
// ============================================================================
// ttg_vertex_ram
// Single-port vertex attribute memory, registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module ttg_vertex_ram (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire ttg_pkg::t_addr   i_addr,
    input  wire ttg_pkg::t_vertex i_wdata,
    output ttg_pkg::t_vertex      o_rdata
);
    import ttg_pkg::*;

    t_vertex r_mem [VERTEX_DEPTH];
    t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/ttg_tangent_pipe.sv
// ============================================================================
// ttg_tangent_pipe
// Edge/UV arithmetic, normalising shift and 8-step byte search.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module ttg_tangent_pipe (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ttg_pkg::t_pipe_ctl i_ctl,
    input  wire ttg_pkg::t_vertex   i_p0,
    input  wire ttg_pkg::t_vertex   i_p1,
    input  wire ttg_pkg::t_vertex   i_p2,
    input  wire ttg_pkg::t_corners  i_corners,
    output logic                    o_valid,
    output ttg_pkg::t_result        o_result
);
    import ttg_pkg::*;

    typedef logic signed [EDGE_W-1:0] t_edge;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic [DIFF_W-1:0]        t_mag;

    // (2t-255)^2, computed as a 16-bit value
    function automatic logic [15:0] c_sq(input logic [7:0] t);
        logic signed [9:0]  c;
        logic signed [19:0] p;
        c = $signed({1'b0, t, 1'b0}) - 10'sd255;
        p = c * c;
        return p[15:0];
    endfunction

    function automatic logic fits(input logic [7:0] t, input logic xneg,
                                  input logic [SUM_W-1:0] s, input logic [D2_W-1:0] d2);
        logic [PRD_W-1:0] pr;
        logic             r;
        pr = PRD_W'(c_sq(t)) * PRD_W'(s);
        if (t <= 8'd127) begin
            r = !xneg || (pr >= PRD_W'(d2));
        end else begin
            r = !xneg && (pr <= PRD_W'(d2));
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] bit_len(input t_mag w);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < DIFF_W; i++) begin
            if (w[i]) n = LEN_W'(i + 1);
        end
        return n;
    endfunction

    logic en;
    assign en = i_ctl.en;

    // stage 1: differences
    logic r1_v;
    t_edge r1_e1 [3], r1_e2 [3];
    t_edge r1_du1, r1_dv1, r1_du2, r1_dv2;
    t_corners r1_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_ctl.launch;
        if (en) begin
            r1_e1[0] <= EDGE_W'(i_p1.x) - EDGE_W'(i_p0.x);
            r1_e1[1] <= EDGE_W'(i_p1.y) - EDGE_W'(i_p0.y);
            r1_e1[2] <= EDGE_W'(i_p1.z) - EDGE_W'(i_p0.z);
            r1_e2[0] <= EDGE_W'(i_p2.x) - EDGE_W'(i_p0.x);
            r1_e2[1] <= EDGE_W'(i_p2.y) - EDGE_W'(i_p0.y);
            r1_e2[2] <= EDGE_W'(i_p2.z) - EDGE_W'(i_p0.z);
            r1_du1   <= EDGE_W'(i_p1.u) - EDGE_W'(i_p0.u);
            r1_dv1   <= EDGE_W'(i_p1.v) - EDGE_W'(i_p0.v);
            r1_du2   <= EDGE_W'(i_p2.u) - EDGE_W'(i_p0.u);
            r1_dv2   <= EDGE_W'(i_p2.v) - EDGE_W'(i_p0.v);
            r1_c     <= i_corners;
        end
    end

    // stage 2: products
    logic r2_v;
    t_prod r2_pa, r2_pb, r2_ta [3], r2_tb [3];
    t_corners r2_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
        if (en) begin
            r2_pa <= r1_du1 * r1_dv2;
            r2_pb <= r1_du2 * r1_dv1;
            for (int i = 0; i < 3; i++) begin
                r2_ta[i] <= r1_dv2 * r1_e1[i];
                r2_tb[i] <= r1_dv1 * r1_e2[i];
            end
            r2_c <= r1_c;
        end
    end

    // stage 3: determinant and raw tangent
    logic r3_v;
    t_diff r3_det, r3_comp [3];
    t_corners r3_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
        if (en) begin
            r3_det <= DIFF_W'(r2_pa) - DIFF_W'(r2_pb);
            for (int i = 0; i < 3; i++) begin
                r3_comp[i] <= DIFF_W'(r2_ta[i]) - DIFF_W'(r2_tb[i]);
            end
            r3_c <= r2_c;
        end
    end

    // stage 4: sign and magnitude, det sign folded in
    logic r4_v, r4_dz;
    logic [7:0] r4_hw;
    t_mag r4_mag [3];
    logic r4_sg [3];
    t_corners r4_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
        if (en) begin
            r4_dz <= (r3_det == '0);
            r4_hw <= ((r3_det != '0) && !r3_det[DIFF_W-1]) ? HW_NEG : HW_POS;
            for (int i = 0; i < 3; i++) begin
                r4_mag[i] <= r3_comp[i][DIFF_W-1] ? t_mag'(~r3_comp[i] + 1'b1)
                                                  : t_mag'(r3_comp[i]);
                r4_sg[i]  <= r3_comp[i][DIFF_W-1] ^ r3_det[DIFF_W-1];
            end
            r4_c <= r3_c;
        end
    end

    // stage 5: leading-one search, shift amount
    logic r5_v, r5_degen;
    logic [7:0] r5_hw;
    logic [LEN_W-1:0] r5_k;
    t_mag r5_mag [3];
    logic r5_sg [3];
    t_corners r5_c;
    logic [LEN_W-1:0] top;
    assign top = bit_len(r4_mag[0] | r4_mag[1] | r4_mag[2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
        if (en) begin
            r5_degen <= r4_dz || (top == '0);
            r5_hw    <= r4_hw;
            r5_k     <= (top > LEN_W'(RED_BITS)) ? top - LEN_W'(RED_BITS) : '0;
            r5_mag   <= r4_mag;
            r5_sg    <= r4_sg;
            r5_c     <= r4_c;
        end
    end

    // stage 6: reduce to RED_BITS
    logic r6_v, r6_degen;
    logic [7:0] r6_hw;
    logic [RED_BITS-1:0] r6_m [3];
    logic r6_sg [3];
    t_corners r6_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_m[i] <= RED_BITS'(r5_mag[i] >> r5_k);
            end
            r6_degen <= r5_degen;
            r6_hw    <= r5_hw;
            r6_sg    <= r5_sg;
            r6_c     <= r5_c;
        end
    end

    // stage 7: squares
    logic r7_v, r7_degen;
    logic [7:0] r7_hw;
    logic [SQ_W-1:0] r7_sq [3];
    logic r7_xn [3];
    t_corners r7_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= SQ_W'(r6_m[i]) * SQ_W'(r6_m[i]);
                r7_xn[i] <= r6_sg[i] && (r6_m[i] != '0);
            end
            r7_degen <= r6_degen;
            r7_hw    <= r6_hw;
            r7_c     <= r6_c;
        end
    end

    // search stages; index 0 is the sum/scale stage
    logic             r_sv  [STEPS+1];
    logic             r_sdg [STEPS+1];
    logic [7:0]       r_shw [STEPS+1];
    logic [SUM_W-1:0] r_ss  [STEPS+1];
    logic [D2_W-1:0]  r_sd2 [STEPS+1][3];
    logic             r_sxn [STEPS+1][3];
    logic [7:0]       r_sq  [STEPS+1][3];
    t_corners         r_sc  [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else if (en) r_sv[0] <= r7_v;
        if (en) begin
            r_ss[0] <= SUM_W'(r7_sq[0]) + SUM_W'(r7_sq[1]) + SUM_W'(r7_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r_sd2[0][i] <= D2_W'(r7_sq[i]) * D2_W'(64516); // 254^2
                r_sxn[0][i] <= r7_xn[i];
                r_sq[0][i]  <= '0;
            end
            r_sdg[0] <= r7_degen;
            r_shw[0] <= r7_hw;
            r_sc[0]  <= r7_c;
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam logic [7:0] BIT = 8'(1 << (STEPS - 1 - j));
        logic [7:0] cand [3];
        logic       take [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                cand[i] = r_sq[j][i] | BIT;
                take[i] = (cand[i] <= HW_POS) &&
                          fits(cand[i], r_sxn[j][i], r_ss[j], r_sd2[j][i]);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[j+1] <= 1'b0;
            else if (en) r_sv[j+1] <= r_sv[j];
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[j+1][i] <= take[i] ? cand[i] : r_sq[j][i];
                end
                r_ss[j+1]  <= r_ss[j];
                r_sd2[j+1] <= r_sd2[j];
                r_sxn[j+1] <= r_sxn[j];
                r_sdg[j+1] <= r_sdg[j];
                r_shw[j+1] <= r_shw[j];
                r_sc[j+1]  <= r_sc[j];
            end
        end
    end

    assign o_valid        = r_sv[STEPS];
    assign o_result.tx    = r_sdg[STEPS] ? BYTE_MID : r_sq[STEPS][0];
    assign o_result.ty    = r_sdg[STEPS] ? BYTE_MID : r_sq[STEPS][1];
    assign o_result.tz    = r_sdg[STEPS] ? BYTE_MID : r_sq[STEPS][2];
    assign o_result.hw    = r_shw[STEPS];
    assign o_result.degen = r_sdg[STEPS];
    assign o_result.c     = r_sc[STEPS];
endmodule
`default_nettype wire

// File: rtl/triangle_tangent_generator.sv
// ============================================================================
// triangle_tangent_generator
// Vertex store plus per-triangle tangent and handedness byte generation.
// ============================================================================
// Load transactions (action 0) write one vertex's Q16.16 position and UV into
// a single-port vertex memory and produce no result. For a triangle
// transaction (action 1) the input side waits while its three corners are
// read one per cycle from the single-port memory, unless the datapath is
// frozen, so a new transaction is taken every cycle for loads, barring a
// freeze, and after a triangle only once its third corner read is issued.
// A result passes through the memory read, 7 arithmetic stages, a sum stage,
// an 8-step byte search and the output register. The datapath is fully
// pipelined; it only freezes when its last stage holds a result and the
// output register is still occupied, so bubbles keep draining while a result
// waits. Corner indices wrap modulo the vertex depth. No reset clearing of
// the memory: reading a never-loaded vertex gives undefined bytes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_tangent_generator_defines.svh"
module triangle_tangent_generator (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ttg_item_if.sink     i_item,
    ttg_result_if.source o_result
);
    import ttg_pkg::*;

    typedef enum logic [1:0] {PH_A, PH_B, PH_C} t_phase;

    t_phase    r_phase;
    t_addr     r_a1, r_a2;
    t_corners  r_corners;
    logic      r_tag_v;
    t_phase    r_tag_k;
    t_vertex   r_p0, r_p1;
    logic      r_out_valid;
    t_result   r_res;

    logic      en, accept, last_valid;
    logic      ram_we, ram_rd;
    t_addr     ram_addr;
    t_vertex   ram_wdata, ram_rdata;
    t_pipe_ctl ctl;
    t_result   pipe_res;

    // freeze only when a finished result has nowhere to go
    assign en = !(last_valid && r_out_valid && !o_result.ready);
    assign i_item.ready = en && (r_phase == PH_A);
    assign accept = i_item.valid && i_item.ready;

    assign ram_wdata = '{x: i_item.position_x, y: i_item.position_y,
                         z: i_item.position_z, u: i_item.texture_u,
                         v: i_item.texture_v};

    always_comb begin
        ram_addr = t_addr'(i_item.first_corner);
        ram_we   = 1'b0;
        ram_rd   = 1'b0;
        case (r_phase)
            PH_A: begin
                ram_we = accept && (i_item.action == ACT_LOAD);
                ram_rd = accept && (i_item.action == ACT_TRI);
            end
            PH_B: begin
                ram_addr = r_a1;
                ram_rd   = 1'b1;
            end
            PH_C: begin
                ram_addr = r_a2;
                ram_rd   = 1'b1;
            end
            default: begin
                ram_rd = 1'b0;
            end
        endcase
    end

    ttg_vertex_ram u_ram (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // read sequencer and corner collection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_A;
            r_tag_v <= 1'b0;
            r_tag_k <= PH_A;
        end else if (en) begin
            r_tag_v <= ram_rd;
            r_tag_k <= r_phase;
            case (r_phase)
                PH_A:    r_phase <= (accept && (i_item.action == ACT_TRI)) ? PH_B : PH_A;
                PH_B:    r_phase <= PH_C;
                PH_C:    r_phase <= PH_A;
                default: r_phase <= PH_A;
            endcase
        end
        if (en) begin
            if (accept) begin
                r_a1      <= t_addr'(i_item.second_corner);
                r_a2      <= t_addr'(i_item.third_corner);
                r_corners <= '{c0: i_item.first_corner, c1: i_item.second_corner,
                               c2: i_item.third_corner};
            end
            if (r_tag_v && (r_tag_k == PH_A)) r_p0 <= ram_rdata;
            if (r_tag_v && (r_tag_k == PH_B)) r_p1 <= ram_rdata;
        end
    end

    assign ctl.en     = en;
    assign ctl.launch = r_tag_v && (r_tag_k == PH_C);

    ttg_tangent_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_p0      (r_p0),
        .i_p1      (r_p1),
        .i_p2      (ram_rdata),
        .i_corners (r_corners),
        .o_valid   (last_valid),
        .o_result  (pipe_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && last_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (en && last_valid) r_res <= pipe_res;
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.tangent_x_byte    = r_res.tx;
    assign o_result.tangent_y_byte    = r_res.ty;
    assign o_result.tangent_z_byte    = r_res.tz;
    assign o_result.handedness_byte   = r_res.hw;
    assign o_result.degenerate        = r_res.degen;
    assign o_result.out_first_corner  = r_res.c.c0;
    assign o_result.out_second_corner = r_res.c.c1;
    assign o_result.out_third_corner  = r_res.c.c2;

    `TTG_ASSERT_NOW(a_no_take_on_block, i_clk, i_rst_n, last_valid && r_out_valid && !o_result.ready, !i_item.ready, "transaction taken while pipe blocked")
    `TTG_ASSERT_NEXT(a_tri_reads, i_clk, i_rst_n, accept && (i_item.action == ACT_TRI), r_phase == PH_B, "triangle did not start corner reads")
    `TTG_ASSERT_NOW(a_degen_mid, i_clk, i_rst_n, r_out_valid && r_res.degen, (r_res.tx == BYTE_MID) && (r_res.ty == BYTE_MID) && (r_res.tz == BYTE_MID), "degenerate result with non-mid bytes")
endmodule
`default_nettype wire

// File: tb/triangle_tangent_generator_check.sv
// ----------------------------------------------------------------------------
// Tangent result checker
// Watches both channels, keeps its own copy of the vertex stores, predicts the
// tangent bytes of every triangle and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module triangle_tangent_generator_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttg_item_if          i_item,
    ttg_result_if        i_res,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_result_count,
    output int           o_degen_count
);
    import ttg_pkg::*;

    t_coord   pos_x [VERTEX_DEPTH];
    t_coord   pos_y [VERTEX_DEPTH];
    t_coord   pos_z [VERTEX_DEPTH];
    t_coord   tex_u [VERTEX_DEPTH];
    t_coord   tex_v [VERTEX_DEPTH];
    t_result  tangent_q [$];

    typedef logic signed [127:0] t_wide;

    function automatic t_wide widen(t_coord v);
        t_wide w;
        w = v;
        return w;
    endfunction

    // largest q with (2q-255)*sqrt(s) <= 254*x
    function automatic logic [7:0] quant_byte(longint x, longint unsigned s);
        longint          c, d;
        longint unsigned c2, d2;
        bit              ok;
        for (int q = 254; q > 0; q--) begin
            c  = 2 * q - 255;
            d  = 254 * x;
            c2 = c * c;
            d2 = d * d;
            if (c <= 0 && d >= 0)     ok = 1;
            else if (c > 0 && d < 0)  ok = 0;
            else if (c > 0)           ok = (c2 * s <= d2);
            else                      ok = (c2 * s >= d2);
            if (ok) return q[7:0];
        end
        return 8'd0;
    endfunction

    function automatic t_result tangent_of(t_corners cr);
        t_result         r;
        t_addr           a0, a1, a2;
        t_wide           e1 [3], e2 [3];
        t_wide           du1, dv1, du2, dv2, det, comp;
        bit              neg [3];
        longint unsigned mag [3];
        longint          sv [3];
        longint unsigned sum;
        t_wide           absv [3];
        int              top, k;
        a0 = t_addr'(cr.c0 % VERTEX_DEPTH);
        a1 = t_addr'(cr.c1 % VERTEX_DEPTH);
        a2 = t_addr'(cr.c2 % VERTEX_DEPTH);
        e1[0] = widen(pos_x[a1]) - widen(pos_x[a0]);
        e1[1] = widen(pos_y[a1]) - widen(pos_y[a0]);
        e1[2] = widen(pos_z[a1]) - widen(pos_z[a0]);
        e2[0] = widen(pos_x[a2]) - widen(pos_x[a0]);
        e2[1] = widen(pos_y[a2]) - widen(pos_y[a0]);
        e2[2] = widen(pos_z[a2]) - widen(pos_z[a0]);
        du1 = widen(tex_u[a1]) - widen(tex_u[a0]);
        dv1 = widen(tex_v[a1]) - widen(tex_v[a0]);
        du2 = widen(tex_u[a2]) - widen(tex_u[a0]);
        dv2 = widen(tex_v[a2]) - widen(tex_v[a0]);
        det = du1 * dv2 - du2 * dv1;
        r.c     = cr;
        r.tx    = BYTE_MID;
        r.ty    = BYTE_MID;
        r.tz    = BYTE_MID;
        r.degen = 1'b0;
        r.hw    = (det > 0) ? HW_NEG : HW_POS;
        if (det == 0) begin
            r.degen = 1'b1;
            return r;
        end
        top = 0;
        for (int i = 0; i < 3; i++) begin
            comp = dv2 * e1[i] - dv1 * e2[i];
            if (det < 0) comp = -comp;
            neg[i]  = comp < 0;
            absv[i] = neg[i] ? -comp : comp;
            for (int b = 127; b >= 0; b--)
                if (absv[i][b]) begin
                    if (b + 1 > top) top = b + 1;
                    break;
                end
        end
        if (top == 0) begin
            r.degen = 1'b1;
            return r;
        end
        k   = (top > RED_BITS) ? top - RED_BITS : 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = 64'(absv[i] >> k);
            sv[i]  = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
            sum   += mag[i] * mag[i];
        end
        r.tx = quant_byte(sv[0], sum);
        r.ty = quant_byte(sv[1], sum);
        r.tz = quant_byte(sv[2], sum);
        return r;
    endfunction

    assign o_pending = tangent_q.size();

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
        o_degen_count  = 0;
    end

    always @(posedge i_clk) begin
        t_corners cr;
        t_result  want, got;
        t_addr    wa;
        if (i_rst_n && i_item.valid && i_item.ready) begin
            cr = '{i_item.first_corner, i_item.second_corner, i_item.third_corner};
            if (i_item.action == ACT_LOAD) begin
                wa = t_addr'(i_item.first_corner % VERTEX_DEPTH);
                pos_x[wa] = i_item.position_x;
                pos_y[wa] = i_item.position_y;
                pos_z[wa] = i_item.position_z;
                tex_u[wa] = i_item.texture_u;
                tex_v[wa] = i_item.texture_v;
            end else begin
                tangent_q.push_back(tangent_of(cr));
            end
        end
        if (i_rst_n && i_res.valid && i_res.ready) begin
            got = '{i_res.tangent_x_byte, i_res.tangent_y_byte, i_res.tangent_z_byte,
                    i_res.handedness_byte, i_res.degenerate,
                    '{i_res.out_first_corner, i_res.out_second_corner,
                      i_res.out_third_corner}};
            o_result_count <= o_result_count + 1;
            if (got.degen) o_degen_count <= o_degen_count + 1;
            if (tangent_q.size() == 0) begin
                if (o_fail_count < 10)
                    $display("ERROR: unexpected result %h", got);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = tangent_q.pop_front();
                if (got.tx !== want.tx || got.ty !== want.ty || got.tz !== want.tz ||
                    got.hw !== want.hw || got.degen !== want.degen ||
                    got.c !== want.c) begin
                    if (o_fail_count < 10)
                        $display("ERROR: corners %0d/%0d/%0d exp t=%0d,%0d,%0d w=%0d d=%0b %0d/%0d/%0d got t=%0d,%0d,%0d w=%0d d=%0b %0d/%0d/%0d",
                                 want.c.c0, want.c.c1, want.c.c2,
                                 want.tx, want.ty, want.tz, want.hw, want.degen,
                                 want.c.c0, want.c.c1, want.c.c2,
                                 got.tx, got.ty, got.tz, got.hw, got.degen,
                                 got.c.c0, got.c.c1, got.c.c2);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

// File: tb/triangle_tangent_generator_test.sv
// ----------------------------------------------------------------------------
// Triangle tangent generator testbench
// Directed vertex/triangle cases followed by about 1150 random transactions,
// with bursty input, a patterned result stall and one long back-pressure hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module triangle_tangent_generator_test;
    import ttg_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 1150;

    logic i_clk;
    logic i_rst_n;

    ttg_item_if   item_ch ();
    ttg_result_if res_ch ();

    int fail_count, pending, result_count, degen_count;
    int sent_count, load_count, tri_count;
    int cycle_count;
    int burst_left;

    // vertices loaded so far; triangles only ever name these
    bit   loaded [VERTEX_DEPTH];
    t_idx loaded_list [$];

    triangle_tangent_generator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    triangle_tangent_generator_check checker_u (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_degen_count  (degen_count)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // watchdog: a run that hangs is a failure
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: ready changes on the falling edge. Mode is redrawn at random
    // among always ready, mostly ready and mostly stalled. Once 300 transactions
    // have been sent, ready is held low while the sender keeps offering, so the
    // pipeline backs up into the input.
    initial begin
        int  mode, hold_left, phase;
        bit  held;
        res_ch.ready = 1'b0;
        hold_left    = 0;
        held         = 0;
        phase        = 0;
        mode         = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            phase++;
            if (phase % 64 == 0) mode = $urandom_range(0, 2);
            if (!held && sent_count >= 300) begin
                held      = 1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready = 1'b0;
            end else begin
                case (mode)
                    0:       res_ch.ready = 1'b1;
                    1:       res_ch.ready = ($urandom_range(0, 9) < 7);
                    default: res_ch.ready = ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    // One transaction. Between bursts valid drops for a random gap; inside a
    // burst valid stays high from one transaction to the next.
    task automatic send(logic act, t_idx c0, t_idx c1, t_idx c2,
                        t_coord x, t_coord y, t_coord z, t_coord u, t_coord v);
        int gap;
        if (burst_left == 0) begin
            item_ch.valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        item_ch.action        = act;
        item_ch.first_corner  = c0;
        item_ch.second_corner = c1;
        item_ch.third_corner  = c2;
        item_ch.position_x    = x;
        item_ch.position_y    = y;
        item_ch.position_z    = z;
        item_ch.texture_u     = u;
        item_ch.texture_v     = v;
        item_ch.valid         = 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        burst_left--;
        sent_count++;
        if (act == ACT_LOAD) begin
            load_count++;
            if (!loaded[c0]) begin
                loaded[c0] = 1;
                loaded_list.push_back(c0);
            end
        end else begin
            tri_count++;
        end
    endtask

    task automatic load(t_idx a, t_coord x, t_coord y, t_coord z, t_coord u, t_coord v);
        send(ACT_LOAD, a, t_idx'($urandom), t_idx'($urandom), x, y, z, u, v);
    endtask

    task automatic triangle(t_idx c0, t_idx c1, t_idx c2);
        send(ACT_TRI, c0, c1, c2, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Mostly mesh-like magnitudes so tangents are well conditioned, with some
    // full-range words and the two extremes.
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            4:       return t_coord'($signed($urandom_range(0, 16)) - 8);
            default: return t_coord'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    function automatic t_idx pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    localparam t_coord ONE  = 32'sh0001_0000;
    localparam t_coord CMAX = 32'h7FFF_FFFF;
    localparam t_coord CMIN = 32'h8000_0000;

    initial begin
        t_idx a, b, c;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_LOAD;
        item_ch.first_corner  = '0;
        item_ch.second_corner = '0;
        item_ch.third_corner  = '0;
        item_ch.position_x    = '0;
        item_ch.position_y    = '0;
        item_ch.position_z    = '0;
        item_ch.texture_u     = '0;
        item_ch.texture_v     = '0;
        sent_count = 0;
        load_count = 0;
        tri_count  = 0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed ---
        load(0, 0, 0, 0, 0, 0);
        load(1, ONE, 0, 0, ONE, 0);
        load(2, 0, ONE, 0, 0, ONE);
        triangle(0, 1, 2);                  // unit tangent, positive det
        triangle(0, 2, 1);                  // mirrored UVs: other handedness
        load(3, 0, 0, ONE, 2 * ONE, 0);
        triangle(0, 1, 3);                  // collinear UVs: zero determinant
        load(4, 0, 0, 0, 0, ONE);
        load(5, 0, 0, 0, ONE, ONE);
        triangle(0, 4, 5);                  // coincident positions: zero-length tangent
        triangle(1, 1, 1);                  // all corners the same vertex
        load(4095, CMAX, CMAX, CMAX, CMAX, CMAX);
        load(4094, CMIN, CMIN, CMIN, CMIN, CMIN);
        load(6, CMAX, CMIN, 0, CMIN, CMAX);
        send(ACT_LOAD, 7, 12'hFFF, 12'hFFF, -1, -1, -1, ONE, -ONE);
        send(ACT_LOAD, 8, 12'h000, 12'h000, 1, 0, -1, -ONE, ONE);
        triangle(4094, 4095, 6);            // widest edges and deltas
        triangle(6, 4095, 4094);
        triangle(4095, 6, 7);
        triangle(7, 8, 0);                  // collinear UVs: zero determinant
        triangle(8, 2, 4095);

        // --- random: mostly triangles over loaded vertices ---
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 3 || loaded_list.size() < 3) begin
                load(t_idx'($urandom), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord());
            end else begin
                a = pick_loaded();
                b = pick_loaded();
                c = ($urandom_range(0, 19) == 0) ? b : pick_loaded();
                triangle(a, b, c);
            end
        end
        item_ch.valid = 1'b0;

        // drain, then a margin for the pipeline depth
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("Covered %0d loads and %0d triangles; %0d results, %0d degenerate.",
                 load_count, tri_count, result_count, degen_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
